// ===== hdl/lgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and helpers of the life generation stencil core.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int DEFAULT_MAX_COLS = 1024;
   localparam int DEFAULT_MAX_ROWS = 1024;

   localparam int DIM_WIDTH = 11;
   localparam logic [DIM_WIDTH-1:0] DIM_RESET = 11'd1024;
   localparam logic [DIM_WIDTH-1:0] DIM_MIN = 11'd2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic REG_TILE_COLS = 1'b0;
   localparam logic REG_TILE_ROWS = 1'b1;

   localparam logic [3:0] LIVE_TWO = 4'd2;
   localparam logic [3:0] LIVE_THREE = 4'd3;

   typedef struct packed {
      logic next_cell;
      logic last_of_tile;
   } result_type;

   function automatic logic [3:0] count_ones9(input logic [8:0] cells);
      logic [3:0] total;
      total = 4'd0;
      for (int i = 0; i < 9; i++) begin
         total = total + {3'd0, cells[i]};
      end
      return total;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/lgs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lgs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1026
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/life_generation_stencil_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_stencil_core
// One B3/S23 generation over a haloed tile streamed in raster order.
// ----------------------------------------------------------------------------
// The core takes one padded cell word per clock while req_stall is low and
// returns one result word for every interior cell after the cell completing
// its window, via the s1 registers and the result queue. The two line stores
// share one RAM of two bits per padded column, read when a cell is accepted
// and written back in the next cycle; that read-modify-write sets the
// sustained rate of one cell per cycle. A three-word result queue lets input
// continue while results wait. The line stores need no clearing after reset.
module life_generation_stencil_core #(
   parameter int MAX_COLS = lgs_pkg::DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = lgs_pkg::DEFAULT_MAX_ROWS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_cell_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_next_cell,
   output logic                                     rsp_last_of_tile,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [lgs_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [lgs_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [lgs_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                     pready
);

   localparam int DEPTH = MAX_COLS + 2;
   localparam int PW = $clog2(MAX_COLS + 2);
   localparam int RW = $clog2(MAX_ROWS + 2);
   localparam int DW = lgs_pkg::DIM_WIDTH;
   localparam int CCW = (PW > DW) ? PW : DW;
   localparam int RCW = (RW > DW) ? RW : DW;

   logic [DW-1:0] tile_cols_ff, tile_cols_in;
   logic [DW-1:0] tile_rows_ff, tile_rows_in;
   logic          csr_write;

   logic [PW-1:0] cols_eff, cols_last;
   logic [RW-1:0] rows_eff, rows_last;
   logic [CCW-1:0] cols_ext;
   logic [RCW-1:0] rows_ext;

   logic [PW-1:0] col_pos_ff, col_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic          req_accept;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_cell_ff;
   logic          s1_produce_ff;
   logic          s1_last_ff;
   logic [PW-1:0] s1_addr_ff;

   logic [1:0]    ram_rd_data;
   logic [1:0]    ram_wr_data;
   logic [8:0]    window_ff, window_in;
   logic [3:0]    neighbors;
   logic          next_value;

   lgs_pkg::result_type fifo_ff [3];
   lgs_pkg::result_type push_word;
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;
   logic [2:0]    pending;

   // Configuration registers.
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      tile_cols_in = tile_cols_ff;
      tile_rows_in = tile_rows_ff;
      if (csr_write) begin
         unique case (paddr[2])
            lgs_pkg::REG_TILE_COLS: tile_cols_in = pwdata[DW-1:0];
            lgs_pkg::REG_TILE_ROWS: tile_rows_in = pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         lgs_pkg::REG_TILE_COLS:
            prdata = {{(lgs_pkg::CSR_DATA_WIDTH-DW){1'b0}}, tile_cols_ff};
         lgs_pkg::REG_TILE_ROWS:
            prdata = {{(lgs_pkg::CSR_DATA_WIDTH-DW){1'b0}}, tile_rows_ff};
         default: prdata = '0;
      endcase
   end

   // Clamp the tile dimensions to the supported range.
   assign cols_ext = CCW'(tile_cols_ff);
   assign rows_ext = RCW'(tile_rows_ff);

   always_comb begin
      if (cols_ext < CCW'(lgs_pkg::DIM_MIN)) begin
         cols_eff = PW'(lgs_pkg::DIM_MIN);
      end else if (cols_ext > CCW'(MAX_COLS)) begin
         cols_eff = PW'(MAX_COLS);
      end else begin
         cols_eff = cols_ext[PW-1:0];
      end
      if (rows_ext < RCW'(lgs_pkg::DIM_MIN)) begin
         rows_eff = RW'(lgs_pkg::DIM_MIN);
      end else if (rows_ext > RCW'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = rows_ext[RW-1:0];
      end
   end

   assign cols_last = cols_eff + PW'(1);
   assign rows_last = rows_eff + RW'(1);

   // Input stage: scan position and line store read.
   assign pending = {1'b0, count_ff} + {2'b00, s1_valid_ff};
   assign req_stall = (pending >= 3'd3);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (req_accept) begin
         if (col_pos_ff == cols_last) begin
            col_pos_in = '0;
            if (row_pos_ff == rows_last) begin
               row_pos_in = '0;
            end else begin
               row_pos_in = row_pos_ff + RW'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + PW'(1);
         end
      end
      if (csr_write) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end
   end

   assign s1_valid_in = req_accept;

   lgs_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Window stage: bit 0 of a store entry is the upper row, bit 1 the middle.
   assign ram_wr_data = {s1_cell_ff, ram_rd_data[1]};

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         window_in = {s1_cell_ff, ram_rd_data[1], ram_rd_data[0], window_ff[8:3]};
      end
   end

   assign neighbors = lgs_pkg::count_ones9(window_in) - {3'd0, window_in[4]};

   always_comb begin
      if (window_in[4]) begin
         next_value = (neighbors == lgs_pkg::LIVE_TWO) ||
                      (neighbors == lgs_pkg::LIVE_THREE);
      end else begin
         next_value = (neighbors == lgs_pkg::LIVE_THREE);
      end
   end

   // Result queue.
   assign push = s1_valid_ff && s1_produce_ff;
   assign pop = rsp_valid && !rsp_stall;
   assign push_word.next_cell = next_value;
   assign push_word.last_of_tile = s1_last_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == 2'd2) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'd2) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_next_cell = fifo_ff[rd_ptr_ff].next_cell;
   assign rsp_last_of_tile = fifo_ff[rd_ptr_ff].last_of_tile;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_cols_ff <= lgs_pkg::DIM_RESET;
         tile_rows_ff <= lgs_pkg::DIM_RESET;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         s1_valid_ff <= 1'b0;
         window_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         tile_cols_ff <= tile_cols_in;
         tile_rows_ff <= tile_rows_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         s1_valid_ff <= s1_valid_in;
         window_ff <= window_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cell_ff <= req_cell_in;
         s1_addr_ff <= col_pos_ff;
         s1_produce_ff <= (row_pos_ff >= RW'(2)) && (col_pos_ff >= PW'(2));
         s1_last_ff <= (row_pos_ff == rows_last) && (col_pos_ff == cols_last);
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 2'd3)
      else $error("result queue overflow");

   a_accept_reaches_window: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word did not reach the window stage");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> col_pos_ff <= cols_last)
      else $error("column position beyond the padded row");
`endif

endmodule
`default_nettype wire
